### rtl/ccbc_pkg.sv
`timescale 1ns / 1ps

package ccbc_pkg;

   // Block geometry
   localparam int BLOCK_W    = 64;
   localparam int NUM_ROUNDS = 8;
   localparam int NUM_RKEYS  = 9;
   localparam int RK_AW      = $clog2(NUM_RKEYS);
   localparam int CSR_IDX_W  = 8;

   typedef logic [7:0]           byte_type;
   typedef logic [0:7][7:0]      block_type;   // element 0 is bits 63..56
   typedef logic [RK_AW-1:0]     rk_addr_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_w_type;

   // Register map of the configuration channel
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_FIRST   = 8'd0,
      CSR_KEY_SECOND  = 8'd1,
      CSR_INIT_VECTOR = 8'd2,
      CSR_DIRECTION   = 8'd3
   } csr_idx_type;

   // Index of the whitening key, also the last step of a block
   localparam rk_addr_type RK_WHITEN = rk_addr_type'(NUM_RKEYS - 1);

   // Round key store write request from the key expansion
   typedef struct packed {
      logic                en;
      rk_addr_type         addr;
      logic [BLOCK_W-1:0]  data;
   } rk_wr_type;

   // Substitution table P
   localparam byte_type PTAB [256] = '{
      8'h29,8'h0d,8'h61,8'h40,8'h9c,8'heb,8'h9e,8'h8f,8'h1f,8'h85,8'h5f,8'h58,8'h5b,8'h01,8'h39,8'h86,
      8'h97,8'h2e,8'hd7,8'hd6,8'h35,8'hae,8'h17,8'h16,8'h21,8'hb6,8'h69,8'h4e,8'ha5,8'h72,8'h87,8'h08,
      8'h3c,8'h18,8'he6,8'he7,8'hfa,8'had,8'hb8,8'h89,8'hb7,8'h00,8'hf7,8'h6f,8'h73,8'h84,8'h11,8'h63,
      8'h3f,8'h96,8'h7f,8'h6e,8'hbf,8'h14,8'h9d,8'hac,8'ha4,8'h0e,8'h7e,8'hf6,8'h20,8'h4a,8'h62,8'h30,
      8'h03,8'hc5,8'h4b,8'h5a,8'h46,8'ha3,8'h44,8'h65,8'h7d,8'h4d,8'h3d,8'h42,8'h79,8'h49,8'h1b,8'h5c,
      8'hf5,8'h6c,8'hb5,8'h94,8'h54,8'hff,8'h56,8'h57,8'h0b,8'hf4,8'h43,8'h0c,8'h4f,8'h70,8'h6d,8'h0a,
      8'he4,8'h02,8'h3e,8'h2f,8'ha2,8'h47,8'he0,8'hc1,8'hd5,8'h1a,8'h95,8'ha7,8'h51,8'h5e,8'h33,8'h2b,
      8'h5d,8'hd4,8'h1d,8'h2c,8'hee,8'h75,8'hec,8'hdd,8'h7c,8'h4c,8'ha6,8'hb4,8'h78,8'h48,8'h3a,8'h32,
      8'h98,8'haf,8'hc0,8'he1,8'h2d,8'h09,8'h0f,8'h1e,8'hb9,8'h27,8'h8a,8'he9,8'hbd,8'he3,8'h9f,8'h07,
      8'hb1,8'hea,8'h92,8'h93,8'h53,8'h6a,8'h31,8'h10,8'h80,8'hf2,8'hd8,8'h9b,8'h04,8'h36,8'h06,8'h8e,
      8'hbe,8'ha9,8'h64,8'h45,8'h38,8'h1c,8'h7a,8'h6b,8'hf3,8'ha1,8'hf0,8'hcd,8'h37,8'h25,8'h15,8'h81,
      8'hfb,8'h90,8'he8,8'hd9,8'h7b,8'h52,8'h19,8'h28,8'h26,8'h88,8'hfc,8'hd1,8'he2,8'h8c,8'ha0,8'h34,
      8'h82,8'h67,8'hda,8'hcb,8'hc7,8'h41,8'he5,8'hc4,8'hc8,8'hef,8'hdb,8'hc3,8'hcc,8'hab,8'hce,8'hed,
      8'hd0,8'hbb,8'hd3,8'hd2,8'h71,8'h68,8'h13,8'h12,8'h9a,8'hb3,8'hc2,8'hca,8'hde,8'h77,8'hdc,8'hdf,
      8'h66,8'h83,8'hbc,8'h8d,8'h60,8'hc6,8'h22,8'h23,8'hb2,8'h8b,8'h91,8'h05,8'h76,8'hcf,8'h74,8'hc9,
      8'haa,8'hf1,8'h99,8'ha8,8'h59,8'h50,8'h3b,8'h2a,8'hfe,8'hf9,8'h24,8'hb0,8'hba,8'hfd,8'hf8,8'h55
   };

   // Constant mixing steps: positions and constants
   localparam int       CPOS_L [8] = '{0, 4, 1, 5, 0, 1, 2, 3};
   localparam int       CPOS_R [8] = '{2, 6, 3, 7, 4, 5, 6, 7};
   localparam byte_type CVAL_L [8] = '{8'hb7, 8'h51, 8'h8a, 8'h2a, 8'hbf, 8'h58, 8'h9c, 8'hf3};
   localparam byte_type CVAL_R [8] = '{8'he1, 8'h62, 8'hed, 8'h6a, 8'h71, 8'h80, 8'hf4, 8'hc7};

   localparam byte_type MASK_ODD  = 8'h55;
   localparam byte_type MASK_EVEN = 8'hAA;

   function automatic byte_type psub(input byte_type v);
      return PTAB[v];
   endfunction

   function automatic byte_type rotl1(input byte_type v);
      return {v[6:0], v[7]};
   endfunction

   // Forward mixing of a byte pair, returns {left, right}
   function automatic logic [15:0] mix(input byte_type l, input byte_type r,
                                       input byte_type cl, input byte_type cr);
      byte_type x;
      byte_type rx;
      byte_type y;
      x  = l ^ cl;
      rx = rotl1(x);
      y  = r ^ cr;
      return {psub((rx & MASK_ODD) ^ x ^ y), psub(rx ^ y)};
   endfunction

   // Inverse mixing of a byte pair, returns {left, right}
   function automatic logic [15:0] unmix(input byte_type l, input byte_type r,
                                         input byte_type cl, input byte_type cr);
      byte_type pyr;
      byte_type pxp;
      byte_type xl;
      pyr = psub(r);
      pxp = psub(l) ^ pyr;
      xl  = (rotl1(pxp) & MASK_EVEN) ^ pxp;
      return {xl ^ cl, rotl1(xl) ^ pyr ^ cr};
   endfunction

endpackage

### rtl/ccbc_if.sv
`timescale 1ns / 1ps

// Block request channel
interface ccbc_req_if
   import ccbc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] data_block;
   logic               chain_start;

   modport source (output valid, output data_block, output chain_start, input ready);
   modport sink   (input valid, input data_block, input chain_start, output ready);
endinterface

// Result channel
interface ccbc_rsp_if
   import ccbc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] result_block;

   modport source (output valid, output result_block, input ready);
   modport sink   (input valid, input result_block, output ready);
endinterface

// Configuration write channel
interface ccbc_csr_if
   import ccbc_pkg::*;
();
   logic               valid;
   logic               ready;
   csr_idx_w_type      index;
   logic [BLOCK_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/ccbc_ram.sv
`timescale 1ns / 1ps

module ccbc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ccbc_kexp.sv
`timescale 1ns / 1ps

module ccbc_kexp
   import ccbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [BLOCK_W-1:0] key_first,
   input  logic [BLOCK_W-1:0] key_second,
   output logic               busy,
   output rk_wr_type          rk_wr
);

   logic               busy_ff;
   logic               busy_in;
   rk_addr_type        cnt_ff;
   rk_addr_type        cnt_in;
   logic [BLOCK_W-1:0] older_ff;
   logic [BLOCK_W-1:0] older_in;
   block_type          prev_ff;
   block_type          prev_in;
   block_type          subst;
   block_type          trans;
   logic [BLOCK_W-1:0] rkey;

   // Derive one round key: table offset, substitute, transpose, fold in key two back
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         subst[j] = psub(prev_ff[j] ^ PTAB[{1'b0, cnt_ff, 3'(j)}]);
      end
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            trans[i][7-j] = subst[j][7-i];
         end
      end
      rkey = older_ff ^ trans;
   end

   // Advance the schedule by one key per cycle
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      older_in = older_ff;
      prev_in  = prev_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         older_in = key_second;
         prev_in  = key_first;
      end else if (busy_ff) begin
         older_in = prev_ff;
         prev_in  = rkey;
         cnt_in   = cnt_ff + rk_addr_type'(1);
         if (cnt_ff == RK_WHITEN) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      older_ff <= older_in;
      prev_ff  <= prev_in;
   end

   assign busy         = busy_ff;
   assign rk_wr.en     = busy_ff;
   assign rk_wr.addr   = cnt_ff;
   assign rk_wr.data   = rkey;

endmodule

### rtl/ccbc_round.sv
`timescale 1ns / 1ps

module ccbc_round
   import ccbc_pkg::*;
(
   input  logic               decrypt,
   input  logic [BLOCK_W-1:0] state_in,
   input  logic [BLOCK_W-1:0] round_key,
   output logic [BLOCK_W-1:0] state_out
);

   block_type m;
   block_type k;

   // One cipher round: key layer and two constant layers, or their inverse
   always_comb begin
      m = state_in;
      k = round_key;
      if (!decrypt) begin
         for (int s = 0; s < 4; s++) begin
            {m[2*s], m[2*s+1]} = mix(m[2*s], m[2*s+1], k[2*s], k[2*s+1]);
         end
         for (int s = 0; s < 8; s++) begin
            {m[CPOS_L[s]], m[CPOS_R[s]]} =
               mix(m[CPOS_L[s]], m[CPOS_R[s]], CVAL_L[s], CVAL_R[s]);
         end
      end else begin
         for (int s = 7; s >= 0; s--) begin
            {m[CPOS_L[s]], m[CPOS_R[s]]} =
               unmix(m[CPOS_L[s]], m[CPOS_R[s]], CVAL_L[s], CVAL_R[s]);
         end
         for (int s = 0; s < 4; s++) begin
            {m[2*s], m[2*s+1]} = unmix(m[2*s], m[2*s+1], k[2*s], k[2*s+1]);
         end
      end
      state_out = m;
   end

endmodule

### rtl/cs_cipher_cbc_engine_top.sv
`timescale 1ns / 1ps

// 64-bit block cipher engine in CBC mode.
// Channels: req_bus takes one request (data_block, chain_start), rsp_bus returns
// one result_block per request in order, csr_bus writes the four registers:
// key_word_first, key_word_second, init_vector and direction (0 encrypt, 1 decrypt).
// A write to either key word expands the nine round keys into the key store,
// one key per cycle; while that runs neither requests nor writes are taken.
// Write both key words before the first request.
// A request runs one step per cycle: eight rounds and the key whitening, each
// step fed by one read of the round key store. The result lands in the output
// register at the last step. A new request is taken only once the engine is
// idle again, not while the previous one is still in its round loop.
// chain_start reloads the feedback from init_vector before the block.
// The output register holds a result until it is taken; a request may be
// accepted meanwhile, and its last step waits while the output is still full.
// Reset clears the feedback, init_vector, direction and key words; the round
// key store is not cleared and holds nothing usable until a key write.
module cs_cipher_cbc_engine_top
   import ccbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ccbc_req_if.sink          req_bus,
   ccbc_rsp_if.source        rsp_bus,
   ccbc_csr_if.sink          csr_bus
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff;
   rk_addr_type        step_ff;
   logic [BLOCK_W-1:0] data_ff;
   logic [BLOCK_W-1:0] mask_ff;
   logic [BLOCK_W-1:0] fb_ff;
   logic               rsp_valid_ff;
   logic [BLOCK_W-1:0] rsp_data_ff;
   logic [BLOCK_W-1:0] key_first_ff;
   logic [BLOCK_W-1:0] key_first_in;
   logic [BLOCK_W-1:0] key_second_ff;
   logic [BLOCK_W-1:0] key_second_in;
   logic [BLOCK_W-1:0] iv_ff;
   logic               dir_ff;

   logic               req_fire;
   logic               csr_fire;
   logic               key_write;
   logic               kx_busy;
   rk_wr_type          rk_wr;
   logic               rd_en;
   rk_addr_type        rd_addr;
   logic [BLOCK_W-1:0] rkey;
   logic [BLOCK_W-1:0] round_out;
   logic [BLOCK_W-1:0] fb_sel;
   logic [BLOCK_W-1:0] result;
   logic               last_step;
   logic               out_hold;
   logic               out_load;

   // Handshakes
   assign csr_bus.ready = (state_ff == ST_IDLE) && !kx_busy;
   assign req_bus.ready = (state_ff == ST_IDLE) && !kx_busy && !csr_bus.valid;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_block = rsp_data_ff;

   // Decode writes to the key words
   always_comb begin
      key_first_in  = key_first_ff;
      key_second_in = key_second_ff;
      key_write     = 1'b0;
      if (csr_fire) begin
         case (csr_bus.index)
            CSR_KEY_FIRST: begin
               key_first_in = csr_bus.wdata;
               key_write    = 1'b1;
            end
            CSR_KEY_SECOND: begin
               key_second_in = csr_bus.wdata;
               key_write     = 1'b1;
            end
            default: begin
               key_write = 1'b0;
            end
         endcase
      end
   end

   // Round key expansion
   ccbc_kexp u_kexp (
      .clock      (clock),
      .reset      (reset),
      .start      (key_write),
      .key_first  (key_first_in),
      .key_second (key_second_in),
      .busy       (kx_busy),
      .rk_wr      (rk_wr)
   );

   // Round key store
   ccbc_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (NUM_RKEYS)
   ) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_wr.en),
      .wr_addr (rk_wr.addr),
      .wr_data (rk_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rkey)
   );

   // Prefetch the key for the next step
   assign last_step = (step_ff == RK_WHITEN);
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (req_fire) begin
         rd_en   = 1'b1;
         rd_addr = dir_ff ? RK_WHITEN : rk_addr_type'(0);
      end else if ((state_ff == ST_RUN) && !last_step) begin
         rd_en   = 1'b1;
         rd_addr = dir_ff ? rk_addr_type'(RK_WHITEN - step_ff - rk_addr_type'(1))
                          : rk_addr_type'(step_ff + rk_addr_type'(1));
      end
   end

   ccbc_round u_round (
      .decrypt   (dir_ff),
      .state_in  (data_ff),
      .round_key (rkey),
      .state_out (round_out)
   );

   assign fb_sel   = req_bus.chain_start ? iv_ff : fb_ff;
   assign result   = dir_ff ? (round_out ^ mask_ff) : (data_ff ^ rkey);
   assign out_hold = rsp_valid_ff && !rsp_bus.ready;
   assign out_load = (state_ff == ST_RUN) && last_step && !out_hold;

   // Sequencer, register writes, chaining and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         fb_ff         <= '0;
         iv_ff         <= '0;
         dir_ff        <= 1'b0;
         key_first_ff  <= '0;
         key_second_ff <= '0;
      end else begin
         key_first_ff  <= key_first_in;
         key_second_ff <= key_second_in;
         if (csr_fire) begin
            case (csr_bus.index)
               CSR_INIT_VECTOR: iv_ff  <= csr_bus.wdata;
               CSR_DIRECTION:   dir_ff <= csr_bus.wdata[0];
               default:         ;
            endcase
         end
         if (rsp_valid_ff && rsp_bus.ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  data_ff  <= dir_ff ? req_bus.data_block : (req_bus.data_block ^ fb_sel);
                  mask_ff  <= fb_sel;
                  fb_ff    <= dir_ff ? req_bus.data_block : fb_sel;
                  step_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (!last_step) begin
                  if (dir_ff && (step_ff == rk_addr_type'(0))) begin
                     data_ff <= data_ff ^ rkey;
                  end else begin
                     data_ff <= round_out;
                  end
                  step_ff <= step_ff + rk_addr_type'(1);
               end else if (!out_hold) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result;
                  if (!dir_ff) begin
                     fb_ff <= result;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ccbc_pkg::*;

   // Direction codes of the direction register
   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   // Register indexes past the end of the map, written to check they are ignored
   localparam csr_idx_w_type CSR_IDX_FIRST_UNUSED = 8'd4;
   localparam csr_idx_w_type CSR_IDX_LAST         = 8'hFF;

   localparam logic [63:0] WORD_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] WORD_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] WORD_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [63:0] WORD_ALT_5 = 64'h5555_5555_5555_5555;

   localparam logic [7:0] ODD_BITS  = 8'h55;
   localparam logic [7:0] EVEN_BITS = 8'hAA;

   typedef logic [0:7][7:0] byte_vec_type;   // element 0 is bits 63..56

   // Substitution table of the cipher
   localparam logic [7:0] SUB_TABLE [256] = '{
      8'h29, 8'h0d, 8'h61, 8'h40, 8'h9c, 8'heb, 8'h9e, 8'h8f,
      8'h1f, 8'h85, 8'h5f, 8'h58, 8'h5b, 8'h01, 8'h39, 8'h86,
      8'h97, 8'h2e, 8'hd7, 8'hd6, 8'h35, 8'hae, 8'h17, 8'h16,
      8'h21, 8'hb6, 8'h69, 8'h4e, 8'ha5, 8'h72, 8'h87, 8'h08,
      8'h3c, 8'h18, 8'he6, 8'he7, 8'hfa, 8'had, 8'hb8, 8'h89,
      8'hb7, 8'h00, 8'hf7, 8'h6f, 8'h73, 8'h84, 8'h11, 8'h63,
      8'h3f, 8'h96, 8'h7f, 8'h6e, 8'hbf, 8'h14, 8'h9d, 8'hac,
      8'ha4, 8'h0e, 8'h7e, 8'hf6, 8'h20, 8'h4a, 8'h62, 8'h30,
      8'h03, 8'hc5, 8'h4b, 8'h5a, 8'h46, 8'ha3, 8'h44, 8'h65,
      8'h7d, 8'h4d, 8'h3d, 8'h42, 8'h79, 8'h49, 8'h1b, 8'h5c,
      8'hf5, 8'h6c, 8'hb5, 8'h94, 8'h54, 8'hff, 8'h56, 8'h57,
      8'h0b, 8'hf4, 8'h43, 8'h0c, 8'h4f, 8'h70, 8'h6d, 8'h0a,
      8'he4, 8'h02, 8'h3e, 8'h2f, 8'ha2, 8'h47, 8'he0, 8'hc1,
      8'hd5, 8'h1a, 8'h95, 8'ha7, 8'h51, 8'h5e, 8'h33, 8'h2b,
      8'h5d, 8'hd4, 8'h1d, 8'h2c, 8'hee, 8'h75, 8'hec, 8'hdd,
      8'h7c, 8'h4c, 8'ha6, 8'hb4, 8'h78, 8'h48, 8'h3a, 8'h32,
      8'h98, 8'haf, 8'hc0, 8'he1, 8'h2d, 8'h09, 8'h0f, 8'h1e,
      8'hb9, 8'h27, 8'h8a, 8'he9, 8'hbd, 8'he3, 8'h9f, 8'h07,
      8'hb1, 8'hea, 8'h92, 8'h93, 8'h53, 8'h6a, 8'h31, 8'h10,
      8'h80, 8'hf2, 8'hd8, 8'h9b, 8'h04, 8'h36, 8'h06, 8'h8e,
      8'hbe, 8'ha9, 8'h64, 8'h45, 8'h38, 8'h1c, 8'h7a, 8'h6b,
      8'hf3, 8'ha1, 8'hf0, 8'hcd, 8'h37, 8'h25, 8'h15, 8'h81,
      8'hfb, 8'h90, 8'he8, 8'hd9, 8'h7b, 8'h52, 8'h19, 8'h28,
      8'h26, 8'h88, 8'hfc, 8'hd1, 8'he2, 8'h8c, 8'ha0, 8'h34,
      8'h82, 8'h67, 8'hda, 8'hcb, 8'hc7, 8'h41, 8'he5, 8'hc4,
      8'hc8, 8'hef, 8'hdb, 8'hc3, 8'hcc, 8'hab, 8'hce, 8'hed,
      8'hd0, 8'hbb, 8'hd3, 8'hd2, 8'h71, 8'h68, 8'h13, 8'h12,
      8'h9a, 8'hb3, 8'hc2, 8'hca, 8'hde, 8'h77, 8'hdc, 8'hdf,
      8'h66, 8'h83, 8'hbc, 8'h8d, 8'h60, 8'hc6, 8'h22, 8'h23,
      8'hb2, 8'h8b, 8'h91, 8'h05, 8'h76, 8'hcf, 8'h74, 8'hc9,
      8'haa, 8'hf1, 8'h99, 8'ha8, 8'h59, 8'h50, 8'h3b, 8'h2a,
      8'hfe, 8'hf9, 8'h24, 8'hb0, 8'hba, 8'hfd, 8'hf8, 8'h55
   };

   // Fixed mixing steps of a round: byte positions and constants
   localparam int         FIX_POS_L [8] = '{0, 4, 1, 5, 0, 1, 2, 3};
   localparam int         FIX_POS_R [8] = '{2, 6, 3, 7, 4, 5, 6, 7};
   localparam logic [7:0] FIX_VAL_L [8] = '{8'hb7, 8'h51, 8'h8a, 8'h2a,
                                            8'hbf, 8'h58, 8'h9c, 8'hf3};
   localparam logic [7:0] FIX_VAL_R [8] = '{8'he1, 8'h62, 8'hed, 8'h6a,
                                            8'h71, 8'h80, 8'hf4, 8'hc7};

   logic clock = 1'b0;
   logic reset;

   ccbc_req_if req_bus ();
   ccbc_rsp_if rsp_bus ();
   ccbc_csr_if csr_bus ();

   cs_cipher_cbc_engine_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the engine's registers and chaining state
   logic [63:0] key_first  = WORD_ZERO;
   logic [63:0] key_second = WORD_ZERO;
   logic [63:0] init_vec   = WORD_ZERO;
   logic        decrypt_sel = DIR_ENCRYPT;
   logic [63:0] chain_fb   = WORD_ZERO;
   logic [63:0] round_keys [9];

   logic [63:0] pending_blocks [$];
   int          fail_count   = 0;
   int          snd_idle_pct = 25;
   int          rcv_idle_pct = 65;

   always #5 clock = ~clock;

   function automatic logic [7:0] rot_left(input logic [7:0] v);
      return {v[6:0], v[7]};
   endfunction

   // Forward mixing of a byte pair, returns {left, right}
   function automatic logic [15:0] fwd_pair(input logic [7:0] l, input logic [7:0] r,
                                            input logic [7:0] cl, input logic [7:0] cr);
      logic [7:0] x;
      logic [7:0] rx;
      logic [7:0] y;
      x  = l ^ cl;
      rx = rot_left(x);
      y  = r ^ cr;
      return {SUB_TABLE[(rx & ODD_BITS) ^ x ^ y], SUB_TABLE[rx ^ y]};
   endfunction

   // Inverse mixing of a byte pair, returns {left, right}
   function automatic logic [15:0] inv_pair(input logic [7:0] l, input logic [7:0] r,
                                            input logic [7:0] cl, input logic [7:0] cr);
      logic [7:0] pyr;
      logic [7:0] pxp;
      logic [7:0] xl;
      pyr = SUB_TABLE[r];
      pxp = SUB_TABLE[l] ^ pyr;
      xl  = (rot_left(pxp) & EVEN_BITS) ^ pxp;
      return {xl ^ cl, rot_left(xl) ^ pyr ^ cr};
   endfunction

   // Derive all nine round keys from the two key words
   function automatic void expand_keys();
      logic [63:0]  older;
      logic [63:0]  prev;
      byte_vec_type p;
      byte_vec_type t;
      older = key_second;
      prev  = key_first;
      for (int n = 0; n < 9; n++) begin
         p = prev;
         for (int j = 0; j < 8; j++) begin
            p[j] = SUB_TABLE[p[j] ^ SUB_TABLE[n * 8 + j]];
         end
         // transpose the 8x8 bit matrix
         for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
               t[i][7 - j] = p[j][7 - i];
            end
         end
         round_keys[n] = older ^ t;
         older = prev;
         prev  = round_keys[n];
      end
   endfunction

   function automatic logic [63:0] cipher_fwd(input logic [63:0] w);
      byte_vec_type m;
      byte_vec_type k;
      logic [15:0]  pr;
      m = w;
      for (int r = 0; r < 8; r++) begin
         k = round_keys[r];
         for (int s = 0; s < 8; s += 2) begin
            pr = fwd_pair(m[s], m[s + 1], k[s], k[s + 1]);
            m[s] = pr[15:8];
            m[s + 1] = pr[7:0];
         end
         for (int s = 0; s < 8; s++) begin
            pr = fwd_pair(m[FIX_POS_L[s]], m[FIX_POS_R[s]], FIX_VAL_L[s], FIX_VAL_R[s]);
            m[FIX_POS_L[s]] = pr[15:8];
            m[FIX_POS_R[s]] = pr[7:0];
         end
      end
      return m ^ round_keys[8];
   endfunction

   function automatic logic [63:0] cipher_inv(input logic [63:0] w);
      byte_vec_type m;
      byte_vec_type k;
      logic [15:0]  pr;
      m = w ^ round_keys[8];
      for (int r = 7; r >= 0; r--) begin
         k = round_keys[r];
         for (int s = 7; s >= 4; s--) begin
            pr = inv_pair(m[FIX_POS_L[s]], m[FIX_POS_R[s]], FIX_VAL_L[s], FIX_VAL_R[s]);
            m[FIX_POS_L[s]] = pr[15:8];
            m[FIX_POS_R[s]] = pr[7:0];
         end
         for (int s = 0; s < 4; s++) begin
            pr = inv_pair(m[FIX_POS_L[s]], m[FIX_POS_R[s]], FIX_VAL_L[s], FIX_VAL_R[s]);
            m[FIX_POS_L[s]] = pr[15:8];
            m[FIX_POS_R[s]] = pr[7:0];
         end
         for (int s = 0; s < 8; s += 2) begin
            pr = inv_pair(m[s], m[s + 1], k[s], k[s + 1]);
            m[s] = pr[15:8];
            m[s + 1] = pr[7:0];
         end
      end
      return m;
   endfunction

   // Work out the result of one request and advance the chaining state
   function automatic logic [63:0] predict_cbc(input logic [63:0] blk, input logic start);
      logic [63:0] res;
      if (start) chain_fb = init_vec;
      if (decrypt_sel == DIR_DECRYPT) begin
         res = cipher_inv(blk) ^ chain_fb;
         chain_fb = blk;
      end else begin
         res = cipher_fwd(blk ^ chain_fb);
         chain_fb = res;
      end
      return res;
   endfunction

   // Mostly random words, with the extremes now and then
   function automatic logic [63:0] pick_word();
      case ($urandom_range(9))
         0: return WORD_ZERO;
         1: return WORD_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Write one register; valid is left high for a following write
   task automatic csr_write(input csr_idx_w_type idx, input logic [63:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_KEY_FIRST: begin
            key_first = val;
            expand_keys();
         end
         CSR_KEY_SECOND: begin
            key_second = val;
            expand_keys();
         end
         CSR_INIT_VECTOR: init_vec = val;
         CSR_DIRECTION: decrypt_sel = val[0];
         default: ;
      endcase
   endtask

   // Send one request after a random gap; valid is left high for the next one
   task automatic send_block(input logic [63:0] blk, input logic start);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_block  <= blk;
      req_bus.chain_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_blocks.push_back(predict_cbc(blk, start));
   endtask

   // Drop the request line and hold until every result has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // Take results at random and compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_blocks.size() == 0) begin
            $error("result_block: expected none, actual %h", rsp_bus.result_block);
            fail_count++;
         end else if (rsp_bus.result_block !== pending_blocks[0]) begin
            $error("result_block: expected %h, actual %h",
                   pending_blocks[0], rsp_bus.result_block);
            fail_count++;
            void'(pending_blocks.pop_front());
         end else begin
            void'(pending_blocks.pop_front());
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Zero keys, then blocks without a chain start: feedback must be the reset zero
   task automatic test_chain_after_reset();
      csr_write(CSR_KEY_FIRST, WORD_ZERO);
      csr_write(CSR_KEY_SECOND, WORD_ZERO);
      csr_write(CSR_INIT_VECTOR, WORD_ONES);
      csr_write(CSR_DIRECTION, {63'd0, DIR_ENCRYPT});
      csr_bus.valid <= 1'b0;
      send_block(WORD_ZERO, 1'b0);
      send_block(WORD_ONES, 1'b0);
      wait_drained();
   endtask

   // All-ones keys, extreme blocks both ways
   task automatic test_extreme_blocks();
      csr_write(CSR_KEY_FIRST, WORD_ONES);
      csr_write(CSR_KEY_SECOND, WORD_ONES);
      csr_write(CSR_INIT_VECTOR, WORD_ZERO);
      csr_write(CSR_DIRECTION, {63'd0, DIR_ENCRYPT});
      csr_bus.valid <= 1'b0;
      send_block(WORD_ZERO, 1'b1);
      send_block(WORD_ONES, 1'b0);
      send_block(WORD_ALT_A, 1'b0);
      send_block(WORD_ALT_5, 1'b1);
      wait_drained();
      // upper bits of the direction word must not matter
      csr_write(CSR_DIRECTION, {63'h7FFF_FFFF_FFFF_FFFF, DIR_DECRYPT});
      csr_bus.valid <= 1'b0;
      send_block(WORD_ZERO, 1'b1);
      send_block(WORD_ONES, 1'b0);
      send_block(WORD_ALT_A, 1'b0);
      send_block(WORD_ALT_5, 1'b1);
      wait_drained();
   endtask

   // Flip direction inside a chain; the feedback carries over as it stands
   task automatic test_direction_mid_chain();
      csr_write(CSR_KEY_FIRST, {$urandom, $urandom});
      csr_write(CSR_KEY_SECOND, {$urandom, $urandom});
      csr_write(CSR_INIT_VECTOR, {$urandom, $urandom});
      csr_write(CSR_DIRECTION, {63'd0, DIR_ENCRYPT});
      csr_bus.valid <= 1'b0;
      send_block({$urandom, $urandom}, 1'b1);
      send_block({$urandom, $urandom}, 1'b0);
      send_block({$urandom, $urandom}, 1'b0);
      wait_drained();
      csr_write(CSR_DIRECTION, {63'd0, DIR_DECRYPT});
      csr_bus.valid <= 1'b0;
      send_block({$urandom, $urandom}, 1'b0);
      send_block({$urandom, $urandom}, 1'b0);
      wait_drained();
      csr_write(CSR_DIRECTION, {63'd0, DIR_ENCRYPT});
      csr_bus.valid <= 1'b0;
      send_block({$urandom, $urandom}, 1'b0);
      wait_drained();
   endtask

   // Writes past the register map must leave every register alone
   task automatic test_unused_index();
      csr_write(CSR_IDX_FIRST_UNUSED, WORD_ONES);
      csr_write(CSR_IDX_LAST, WORD_ONES);
      csr_bus.valid <= 1'b0;
      send_block({$urandom, $urandom}, 1'b0);
      send_block({$urandom, $urandom}, 1'b1);
      wait_drained();
   endtask

   // Rewrite one key word only: the whole schedule is rebuilt from both
   task automatic test_single_key_write();
      csr_write(CSR_KEY_SECOND, {$urandom, $urandom});
      csr_bus.valid <= 1'b0;
      send_block({$urandom, $urandom}, 1'b1);
      send_block({$urandom, $urandom}, 1'b0);
      wait_drained();
   endtask

   // Chains of random length, reconfigured at random between chains
   task automatic test_random_traffic(input int n_items);
      int          sent;
      int          seg_len;
      logic [63:0] dir_word;
      sent = 0;
      while (sent < n_items) begin
         wait_drained();
         if ($urandom_range(1)) csr_write(CSR_KEY_FIRST, pick_word());
         if ($urandom_range(1)) csr_write(CSR_KEY_SECOND, pick_word());
         if ($urandom_range(2) == 0) csr_write(CSR_INIT_VECTOR, pick_word());
         dir_word = {$urandom, $urandom};
         csr_write(CSR_DIRECTION, dir_word);
         if ($urandom_range(9) == 0) begin
            csr_write(csr_idx_w_type'($urandom_range(CSR_IDX_LAST, CSR_IDX_FIRST_UNUSED)),
                      pick_word());
         end
         csr_bus.valid <= 1'b0;
         seg_len = $urandom_range(40, 5);
         for (int i = 0; i < seg_len; i++) begin
            send_block(pick_word(),
                       (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(9) == 0));
         end
         sent += seg_len;
      end
      wait_drained();
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_block  <= WORD_ZERO;
      req_bus.chain_start <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= CSR_KEY_FIRST;
      csr_bus.wdata       <= WORD_ZERO;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_chain_after_reset();
      test_extreme_blocks();
      test_direction_mid_chain();
      test_unused_index();
      test_single_key_write();

      test_random_traffic(160);
      snd_idle_pct = 65;
      rcv_idle_pct = 25;
      test_random_traffic(160);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(160);

      // let any stray result show up
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### files.f
rtl/ccbc_pkg.sv
rtl/ccbc_if.sv
rtl/ccbc_ram.sv
rtl/ccbc_kexp.sv
rtl/ccbc_round.sv
rtl/cs_cipher_cbc_engine_top.sv
tb/sv/testbench.sv
